FILE: sv/bds_pkg.sv
// bds_pkg: shared types and constants of the 2x2 box downscaler
// no dependencies; imported by bds_front, bds_queue, bds_back and the core
`default_nettype none

package bds_pkg;

  // line and channel limits
  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_CHANNELS = 4;
  localparam int NUM_LANES    = 4;

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int SLOT_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WEFF_W     = COL_W + 1;

  // field widths
  localparam int PIX_W  = 8;
  localparam int PSUM_W = PIX_W + 1;
  localparam int QSUM_W = PIX_W + 2;
  localparam int WID_W  = 13;
  localparam int HGT_W  = 16;
  localparam int NCH_W  = 3;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_idx_e;

  localparam logic [WID_W-1:0] WIDTH_RESET  = 13'd1024;
  localparam logic [HGT_W-1:0] HEIGHT_RESET = 16'd1024;
  localparam logic [NCH_W-1:0] NCH_RESET    = 3'd3;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef logic [NUM_LANES-1:0][PIX_W-1:0]  pix_t;
  typedef logic [NUM_LANES-1:0][PSUM_W-1:0] psum_t;

  // one line-buffer operation: store a pair sum (even row) or complete a block (odd row)
  typedef struct packed {
    logic                 emit;
    logic [SLOT_W-1:0]    slot;
    psum_t                pair;
    logic [NUM_LANES-1:0] lane_en;
    logic                 frame_end;
  } bds_op_t;

endpackage

`default_nettype wire

FILE: sv/bds_front.sv
// bds_front: configuration registers, raster counters and pair-sum classification
// depends on bds_pkg; pushes line-buffer operations into bds_queue
`default_nettype none

module bds_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire bds_pkg::pix_t                in_pix_i,
  input  wire logic                         q_full_i,
  output logic                              push_o,
  output bds_pkg::bds_op_t                  op_o
);
  import bds_pkg::*;

  logic [WID_W-1:0]  width_q;
  logic [HGT_W-1:0]  height_q;
  logic [NCH_W-1:0]  nch_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [HGT_W-1:0]  row_q, row_d;
  pix_t              hold_q;

  logic [WEFF_W-1:0] w_eff, nw;
  logic [HGT_W-1:0]  h_eff;
  logic [NCH_W-1:0]  nch_c;
  logic              accept, active;
  logic [SLOT_W-1:0] slot;

  always_comb begin
    if (32'(width_q) > MAX_WIDTH) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else if (width_q == '0) begin
      w_eff = WEFF_W'(1);
    end else begin
      w_eff = WEFF_W'(width_q);
    end
    h_eff = (height_q == '0) ? HGT_W'(1) : height_q;
    nch_c = (32'(nch_q) > MAX_CHANNELS) ? NCH_W'(MAX_CHANNELS) : nch_q;
    nw    = w_eff >> 1;
  end

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign slot       = SLOT_W'(col_q >> 1);
  assign active     = ({1'b0, col_q} < {w_eff[WEFF_W-1:1], 1'b0})
                   && (row_q < {h_eff[HGT_W-1:1], 1'b0});

  // pair completes on the odd column of an active block
  assign push_o = accept && active && col_q[0];

  always_comb begin
    op_o.emit      = row_q[0];
    op_o.slot      = slot;
    op_o.frame_end = (WEFF_W'(slot) == nw - WEFF_W'(1))
                  && (row_q[HGT_W-1:1] == h_eff[HGT_W-1:1] - (HGT_W-1)'(1));
    for (int i = 0; i < NUM_LANES; i++) begin
      op_o.pair[i]    = {1'b0, hold_q[i]} + {1'b0, in_pix_i[i]};
      op_o.lane_en[i] = (32'(nch_c) > i);
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if ({1'b0, col_q} >= w_eff - WEFF_W'(1)) begin
      col_d = '0;
      row_d = (row_q >= h_eff - HGT_W'(1)) ? '0 : row_q + HGT_W'(1);
    end else begin
      col_d = col_q + COL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      nch_q    <= NCH_RESET;
      col_q    <= '0;
      row_q    <= '0;
      hold_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_IMAGE_WIDTH:   width_q  <= cfg_data_i[WID_W-1:0];
          CFG_IMAGE_HEIGHT:  height_q <= cfg_data_i[HGT_W-1:0];
          CFG_CHANNEL_COUNT: nch_q    <= cfg_data_i[NCH_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        if (active && !col_q[0]) begin
          hold_q <= in_pix_i;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/bds_queue.sv
// bds_queue: short flop-based fifo of line-buffer operations
// depends on bds_pkg; sits between bds_front and bds_back
`default_nettype none

module bds_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire bds_pkg::bds_op_t  push_op_i,
  output logic                   full_o,
  output logic                   valid_o,
  output bds_pkg::bds_op_t       head_o,
  input  wire logic              pop_i
);
  import bds_pkg::*;

  bds_op_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue pop while empty");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + QCNT_W'(1)))
    else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

FILE: sv/bds_back.sv
// bds_back: line buffer, block sum and output register
// depends on bds_pkg; drains operations from bds_queue
`default_nettype none

module bds_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              op_valid_i,
  input  wire bds_pkg::bds_op_t  op_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output bds_pkg::pix_t          out_pix_o,
  output logic                   out_frame_end_o
);
  import bds_pkg::*;

  psum_t                line_mem [LINE_DEPTH];
  psum_t                rd_q;
  psum_t                s1_pair_q;
  logic [NUM_LANES-1:0] s1_en_q;
  logic                 s1_fe_q;
  logic                 s1_vld_q;
  logic                 out_vld_q;
  pix_t                 out_pix_q;
  logic                 out_fe_q;

  logic                 s2_free, s1_move, s1_free, rd_en;
  pix_t                 avg;
  logic [QSUM_W-1:0]    lane_sum;

  assign s2_free = !out_vld_q || !out_stall_i;
  assign s1_move = s1_vld_q && s2_free;
  assign s1_free = !s1_vld_q || s1_move;
  // stores drain freely, completions wait for a free slot in the read stage
  assign pop_o   = op_valid_i && (!op_i.emit || s1_free);
  assign rd_en   = pop_o && op_i.emit;

  always_ff @(posedge clk_i) begin
    if (pop_o && !op_i.emit) begin
      line_mem[op_i.slot] <= op_i.pair;
    end
    if (rd_en) begin
      rd_q      <= line_mem[op_i.slot];
      s1_pair_q <= op_i.pair;
      s1_en_q   <= op_i.lane_en;
      s1_fe_q   <= op_i.frame_end;
    end
    if (s1_move) begin
      out_pix_q <= avg;
      out_fe_q  <= s1_fe_q;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_sum = {1'b0, rd_q[i]} + {1'b0, s1_pair_q[i]};
      avg[i]   = s1_en_q[i] ? lane_sum[QSUM_W-1:2] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (rd_en) begin
        s1_vld_q <= 1'b1;
      end else if (s1_move) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_move) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign out_pix_o       = out_pix_q;
  assign out_frame_end_o = out_fe_q;

endmodule

`default_nettype wire

FILE: sv/box_downscale_2x2_core.sv
// box_downscale_2x2_core: 2x2 box-filter downsampler, top level
// depends on bds_pkg, bds_front, bds_queue and bds_back
//
//   port group   direction  handshake             payload
//   in           sink       in_valid_i/in_stall_o  chan_a_i..chan_d_i
//   out          source     out_valid_o/out_stall_i out_a_o..out_d_o, frame_end_o
//   cfg          sink       cfg_we_i               cfg_index_i, cfg_data_i
//
// one input pixel per clock sustained while out_stall_i is low; an output pixel leaves after
// the second pixel of its odd-row pair through the queue, line-buffer read and output register
// the line buffer is one 2048x36 memory with one write or one registered read per cycle
// a stalled output backs up into the 4-deep queue, then stalls the input side
// reset clears counters, queue and output valid; the line buffer is not cleared
`default_nettype none

module box_downscale_2x2_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bds_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [bds_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [bds_pkg::PIX_W-1:0]     chan_a_i,
  input  wire logic [bds_pkg::PIX_W-1:0]     chan_b_i,
  input  wire logic [bds_pkg::PIX_W-1:0]     chan_c_i,
  input  wire logic [bds_pkg::PIX_W-1:0]     chan_d_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [bds_pkg::PIX_W-1:0]          out_a_o,
  output logic [bds_pkg::PIX_W-1:0]          out_b_o,
  output logic [bds_pkg::PIX_W-1:0]          out_c_o,
  output logic [bds_pkg::PIX_W-1:0]          out_d_o,
  output logic                               frame_end_o
);
  import bds_pkg::*;

  pix_t    in_pix, out_pix;
  bds_op_t push_op, head_op;
  logic    push, q_full, q_valid, pop;

  assign in_pix = {chan_d_i, chan_c_i, chan_b_i, chan_a_i};

  bds_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_pix_i    (in_pix),
    .q_full_i    (q_full),
    .push_o      (push),
    .op_o        (push_op)
  );

  bds_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .valid_o   (q_valid),
    .head_o    (head_op),
    .pop_i     (pop)
  );

  bds_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_valid_i      (q_valid),
    .op_i            (head_op),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_pix_o       (out_pix),
    .out_frame_end_o (frame_end_o)
  );

  assign out_a_o = out_pix[0];
  assign out_b_o = out_pix[1];
  assign out_c_o = out_pix[2];
  assign out_d_o = out_pix[3];

endmodule

`default_nettype wire
